@@ rtl/mme_pkg.sv @@
// Package with shared constants, types and helpers of the matrix multiply engine.
package mme_pkg;
    localparam int MAX_DIM = 8;
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int DIM_W = 4;
    localparam int ELEM_W = 16;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int ACC_W = 36;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0]
    {
        REQ_LOAD_A = 2'd0,
        REQ_LOAD_B = 2'd1,
        REQ_START  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_A_ROWS = 2'd0,
        CFG_A_COLS = 2'd1,
        CFG_B_ROWS = 2'd2,
        CFG_B_COLS = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_FEED,
        ST_DRAIN,
        ST_ERROR
    } state_t;

    typedef struct packed
    {
        logic             start;
        logic             feed;
        logic [IDX_W-1:0] step;
    } cell_ctrl_t;

    function automatic logic [IDX_W:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [IDX_W:0] r;
        if (v == '0)
            r = (IDX_W+1)'(1);
        else if (v > DIM_W'(MAX_DIM))
            r = (IDX_W+1)'(MAX_DIM);
        else
            r = v[IDX_W:0];
        return r;
    endfunction
endpackage

@@ rtl/mme_if.sv @@
// Valid-ready channel interfaces for requests, results and configuration.
interface mme_req_if;
    import mme_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [2:0]        row_index;
    logic [2:0]        col_index;
    logic signed [15:0] element_value;
    modport source (output valid, req_type, row_index, col_index, element_value, input ready);
    modport sink (input valid, req_type, row_index, col_index, element_value, output ready);
endinterface

interface mme_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [35:0] out_value;
    logic               last_flag;
    logic               dim_error;
    modport source (output valid, out_row, out_col, out_value, last_flag, dim_error,
                    input ready);
    modport sink (input valid, out_row, out_col, out_value, last_flag, dim_error,
                  output ready);
endinterface

interface mme_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [3:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/mme_cell.sv @@
// One multiply-accumulate cell that owns one column of B and one output column.
module mme_cell
    import mme_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_ctrl_t               ctrl_in,
    output cell_ctrl_t               ctrl_out,
    input  logic                     b_we,
    input  logic [IDX_W-1:0]         b_row,
    input  logic signed [ELEM_W-1:0] b_data,
    input  logic signed [ELEM_W-1:0] a_in,
    output logic signed [ELEM_W-1:0] a_out,
    output logic signed [ACC_W-1:0]  acc
);
    logic signed [ELEM_W-1:0] col_mem [MAX_DIM];
    logic signed [ELEM_W-1:0] b_reg;
    logic signed [ELEM_W-1:0] a_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    cell_ctrl_t               ctrl_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            col_mem[b_row] <= b_data;
        end
        b_reg <= col_mem[ctrl_in.step];
        a_reg <= a_in;
        prod_reg <= a_reg * b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
            prod_valid_reg <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
            prod_valid_reg <= ctrl_reg.feed;
            if (ctrl_reg.start)
                acc_reg <= '0;
            else if (prod_valid_reg)
                acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign ctrl_out = ctrl_reg;
    assign a_out = a_reg;
    assign acc = acc_reg;
endmodule

@@ rtl/mme_ctrl.sv @@
// Sequencer that walks rows of A through the cell chain and emits results.
module mme_ctrl
    import mme_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    mme_req_if.sink              req,
    mme_res_if.source            res,
    mme_cfg_if.sink              cfg,
    output cell_ctrl_t           ctrl,
    output logic                 b_we,
    output logic [IDX_W-1:0]     b_row,
    output logic [IDX_W-1:0]     b_col,
    output logic signed [ELEM_W-1:0] b_data,
    output logic signed [ELEM_W-1:0] a_feed,
    input  logic signed [ACC_W-1:0]  accs [MAX_DIM]
);
    logic signed [ELEM_W-1:0] a_mem [MAX_DIM*MAX_DIM];
    logic [DIM_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    state_t state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next, k_reg, k_next, j_reg, j_next;
    logic [2:0] wait_reg, wait_next;
    logic [IDX_W:0] ar, ac, br, bc;
    logic accept;
    logic a_rd_valid_reg;
    logic signed [ELEM_W-1:0] a_rd_reg;
    logic [IDX_W-1:0] step_reg;
    logic out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] out_row_reg, out_row_next, out_col_reg, out_col_next;
    logic signed [ACC_W-1:0] out_value_reg, out_value_next;
    logic out_last_reg, out_last_next, out_err_reg, out_err_next;
    logic feed;
    logic start_pulse;

    assign ar = clamp_dim(a_rows_reg);
    assign ac = clamp_dim(a_cols_reg);
    assign br = clamp_dim(b_rows_reg);
    assign bc = clamp_dim(b_cols_reg);
    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept = req.valid && req.ready;

    assign b_we = accept && (req.req_type == REQ_LOAD_B);
    assign b_row = req.row_index;
    assign b_col = req.col_index;
    assign b_data = req.element_value;

    always_ff @(posedge clk)
    begin
        if (accept && (req.req_type == REQ_LOAD_A))
            a_mem[{req.row_index, req.col_index}] <= req.element_value;
        a_rd_reg <= a_mem[{i_reg, k_reg}];
        step_reg <= k_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= DIM_W'(MAX_DIM);
            a_cols_reg <= DIM_W'(MAX_DIM);
            b_rows_reg <= DIM_W'(MAX_DIM);
            b_cols_reg <= DIM_W'(MAX_DIM);
            state_reg <= ST_IDLE;
            i_reg <= '0;
            k_reg <= '0;
            j_reg <= '0;
            wait_reg <= '0;
            a_rd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg_idx_t'(cfg.index))
                    CFG_A_ROWS: a_rows_reg <= cfg.data;
                    CFG_A_COLS: a_cols_reg <= cfg.data;
                    CFG_B_ROWS: b_rows_reg <= cfg.data;
                    CFG_B_COLS: b_cols_reg <= cfg.data;
                    default: ;
                endcase
            end
            state_reg <= state_next;
            i_reg <= i_next;
            k_reg <= k_next;
            j_reg <= j_next;
            wait_reg <= wait_next;
            a_rd_valid_reg <= feed;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_row_reg <= out_row_next;
        out_col_reg <= out_col_next;
        out_value_reg <= out_value_next;
        out_last_reg <= out_last_next;
        out_err_reg <= out_err_next;
    end

    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg;
        k_next = k_reg;
        j_next = j_reg;
        wait_next = wait_reg;
        feed = 1'b0;
        start_pulse = 1'b0;
        out_valid_next = out_valid_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        out_value_next = out_value_reg;
        out_last_next = out_last_reg;
        out_err_next = out_err_reg;
        if (out_valid_reg && res.ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.req_type == REQ_START))
                begin
                    i_next = '0;
                    k_next = '0;
                    if (ac != br)
                        state_next = ST_ERROR;
                    else
                    begin
                        start_pulse = 1'b1;
                        state_next = ST_FEED;
                    end
                end
            end
            ST_FEED:
            begin
                feed = 1'b1;
                if ({1'b0, k_reg} == ac - 1'b1)
                begin
                    k_next = '0;
                    wait_next = '0;
                    j_next = '0;
                    state_next = ST_DRAIN;
                end
                else
                    k_next = k_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                if (wait_reg != 3'd4)
                    wait_next = wait_reg + 1'b1;
                else if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_row_next = i_reg;
                    out_col_next = j_reg;
                    out_value_next = accs[j_reg];
                    out_err_next = 1'b0;
                    out_last_next = ({1'b0, i_reg} == ar - 1'b1) &&
                                    ({1'b0, j_reg} == bc - 1'b1);
                    if ({1'b0, j_reg} == bc - 1'b1)
                    begin
                        if ({1'b0, i_reg} == ar - 1'b1)
                            state_next = ST_IDLE;
                        else
                        begin
                            i_next = i_reg + 1'b1;
                            start_pulse = 1'b1;
                            state_next = ST_FEED;
                        end
                    end
                    else
                        j_next = j_reg + 1'b1;
                end
            end
            ST_ERROR:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_row_next = '0;
                    out_col_next = '0;
                    out_value_next = '0;
                    out_last_next = 1'b1;
                    out_err_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign ctrl.start = start_pulse;
    assign ctrl.feed = a_rd_valid_reg;
    assign ctrl.step = step_reg;
    assign a_feed = a_rd_reg;

    assign res.valid = out_valid_reg;
    assign res.out_row = out_row_reg;
    assign res.out_col = out_col_reg;
    assign res.out_value = out_value_reg;
    assign res.last_flag = out_last_reg;
    assign res.dim_error = out_err_reg;
endmodule

@@ rtl/matrix_multiply_engine_core.sv @@
// Top level of the matrix multiply engine: sequencer and chain of MAC cells.
// Load words are taken only while the sequencer is idle and no result word waits. A start
// word passes each row of A in turn, with its control, down a chain of eight cells, one
// cell per cycle, each holding one column of B and one accumulator; for each row the
// sequencer feeds a_cols elements, lets the pipeline drain, then emits b_cols result
// words, stalling while results are not taken. A dimension mismatch gives one error word.
module matrix_multiply_engine_core
    import mme_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mme_req_if.sink   req,
    mme_res_if.source res,
    mme_cfg_if.sink   cfg
);
    cell_ctrl_t ctrl;
    cell_ctrl_t ctrl_link [MAX_DIM+1];
    logic b_we;
    logic [IDX_W-1:0] b_row, b_col;
    logic signed [ELEM_W-1:0] b_data;
    logic signed [ELEM_W-1:0] a_feed;
    logic signed [ELEM_W-1:0] a_link [MAX_DIM+1];
    logic signed [ACC_W-1:0] accs [MAX_DIM];

    mme_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .res    (res),
        .cfg    (cfg),
        .ctrl   (ctrl),
        .b_we   (b_we),
        .b_row  (b_row),
        .b_col  (b_col),
        .b_data (b_data),
        .a_feed (a_feed),
        .accs   (accs)
    );

    assign a_link[0] = a_feed;
    assign ctrl_link[0] = ctrl;

    genvar g;
    generate
        for (g = 0; g < MAX_DIM; g++)
        begin : g_cell
            mme_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl_in  (ctrl_link[g]),
                .ctrl_out (ctrl_link[g+1]),
                .b_we     (b_we && (b_col == IDX_W'(g))),
                .b_row    (b_row),
                .b_data   (b_data),
                .a_in     (a_link[g]),
                .a_out    (a_link[g+1]),
                .acc      (accs[g])
            );
        end
    endgenerate
endmodule

@@ tb/mme_tb_pkg.sv @@
// Scoreboard class that predicts and checks the product words of the matrix multiply engine.
package mme_tb_pkg;
    import mme_pkg::*;

    typedef struct packed
    {
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [35:0] value;
        logic               last;
        logic               err;
    } product_t;

    class product_scoreboard;
        logic signed [15:0] mat_a [MAX_DIM*MAX_DIM];
        logic signed [15:0] mat_b [MAX_DIM*MAX_DIM];
        logic [3:0]         dims [4];
        product_t           pending [$];
        int                 failures;

        function new();
            foreach (mat_a[i])
            begin
                mat_a[i] = '0;
                mat_b[i] = '0;
            end
            foreach (dims[i])
                dims[i] = 4'd8;
            failures = 0;
        endfunction

        function int eff(int v);
            if (v == 0)
                return 1;
            if (v > MAX_DIM)
                return MAX_DIM;
            return v;
        endfunction

        function void note_request(logic [1:0] kind, logic [2:0] r, logic [2:0] c,
                                   logic signed [15:0] v);
            int ar, ac, br, bc;
            logic signed [35:0] acc;
            product_t p;
            ar = eff(dims[CFG_A_ROWS]);
            ac = eff(dims[CFG_A_COLS]);
            br = eff(dims[CFG_B_ROWS]);
            bc = eff(dims[CFG_B_COLS]);
            if (kind == REQ_LOAD_A)
                mat_a[r*MAX_DIM+c] = v;
            else if (kind == REQ_LOAD_B)
                mat_b[r*MAX_DIM+c] = v;
            else if (kind == REQ_START)
            begin
                if (ac != br)
                begin
                    p = '{row: 3'd0, col: 3'd0, value: '0, last: 1'b1, err: 1'b1};
                    pending = {pending, p};
                end
                else
                begin
                    for (int i = 0; i < ar; i++)
                        for (int j = 0; j < bc; j++)
                        begin
                            acc = '0;
                            for (int k = 0; k < ac; k++)
                                acc += 36'(mat_a[i*MAX_DIM+k]) * 36'(mat_b[k*MAX_DIM+j]);
                            p.row = 3'(i);
                            p.col = 3'(j);
                            p.value = acc;
                            p.last = (i == ar-1 && j == bc-1);
                            p.err = 1'b0;
                            pending = {pending, p};
                        end
                end
            end
        endfunction

        function void check_product(product_t got);
            product_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result word row=%0d col=%0d", got.row, got.col);
                failures++;
                return;
            end
            want = pending.pop_front();
            if (got.row !== want.row)
            begin
                $error("out_row expected %0d actual %0d", want.row, got.row);
                failures++;
            end
            if (got.col !== want.col)
            begin
                $error("out_col expected %0d actual %0d", want.col, got.col);
                failures++;
            end
            if (got.value !== want.value)
            begin
                $error("out_value expected %0d actual %0d", want.value, got.value);
                failures++;
            end
            if (got.last !== want.last)
            begin
                $error("last_flag expected %0d actual %0d", want.last, got.last);
                failures++;
            end
            if (got.err !== want.err)
            begin
                $error("dim_error expected %0d actual %0d", want.err, got.err);
                failures++;
            end
        endfunction
    endclass
endpackage

@@ tb/matrix_multiply_engine_core_tb.sv @@
// Top module of the testbench: drives loads, starts and register writes and checks products.
module matrix_multiply_engine_core_tb;
    import mme_pkg::*;
    import mme_tb_pkg::*;

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   quiet_cycles;
    bit   done;

    mme_req_if req ();
    mme_res_if res ();
    mme_cfg_if cfg ();

    product_scoreboard board;

    matrix_multiply_engine_core dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .res   (res.source),
        .cfg   (cfg.sink)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        board = new();
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.req_type = REQ_NONE;
        req.row_index = '0;
        req.col_index = '0;
        req.element_value = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_A_ROWS;
        cfg.data = '0;
        res.ready = 1'b0;
        idle_pct = 32;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res.valid && res.ready)
                board.check_product('{row: res.out_row, col: res.out_col,
                    value: res.out_value, last: res.last_flag, err: res.dim_error});
            res.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000 && !done)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial quiet_cycles = 0;

    task automatic send_request(logic [1:0] kind, logic [2:0] r, logic [2:0] c,
                                logic signed [15:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.req_type <= kind;
        req.row_index <= r;
        req.col_index <= c;
        req.element_value <= v;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        board.note_request(kind, r, c, v);
    endtask

    task automatic wait_empty();
        req.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_dims(int ar, int ac, int br, int bc);
        int vals [4];
        vals = '{ar, ac, br, bc};
        wait_empty();
        for (int i = 0; i < 4; i++)
        begin
            cfg.valid <= 1'b1;
            cfg.index <= cfg_idx_t'(i);
            cfg.data <= 4'(vals[i]);
            @(posedge clk);
            while (!cfg.ready)
                @(posedge clk);
            board.dims[i] = 4'(vals[i]);
        end
        cfg.valid <= 1'b0;
    endtask

    task automatic load_all(bit extreme);
        logic signed [15:0] v;
        for (int r = 0; r < MAX_DIM; r++)
            for (int c = 0; c < MAX_DIM; c++)
            begin
                v = extreme ? ((r + c) % 2 ? 16'sh8000 : 16'sh7fff) : 16'($urandom);
                send_request(REQ_LOAD_A, 3'(r), 3'(c), v);
                v = extreme ? 16'sh8000 : 16'($urandom);
                send_request(REQ_LOAD_B, 3'(r), 3'(c), v);
            end
    endtask

    initial
    begin
        int ar, ac, bc, n;
        @(posedge rst_n);
        @(posedge clk);
        idle_pct = 0;
        load_all(1'b1);
        send_request(REQ_START, 3'd0, 3'd0, 16'sd0);
        write_dims(1, 1, 1, 1);
        send_request(REQ_START, 3'd7, 3'd7, 16'sd0);
        send_request(REQ_NONE, 3'd5, 3'd2, 16'sh1234);
        write_dims(0, 0, 0, 15);
        send_request(REQ_START, 3'd0, 3'd0, 16'sd0);
        write_dims(2, 3, 4, 2);
        send_request(REQ_START, 3'd0, 3'd0, 16'sd0);
        write_dims(8, 8, 8, 8);
        idle_pct = 32;
        load_all(1'b0);
        send_request(REQ_START, 3'd0, 3'd0, 16'sd0);
        n = 0;
        while (n < 60)
        begin
            if (n > 40)
                idle_pct = 32;
            else if (n > 20)
                idle_pct = 0;
            if ($urandom_range(9) == 0)
            begin
                ar = $urandom_range(4, 1);
                ac = $urandom_range(4, 1);
                bc = $urandom_range(4, 1);
                write_dims(ar, ac, ($urandom_range(5) == 0) ? ac + 1 : ac, bc);
            end
            case ($urandom_range(19))
                0: send_request(REQ_NONE, 3'($urandom), 3'($urandom), 16'($urandom));
                1, 2: send_request(REQ_START, 3'($urandom), 3'($urandom), 16'($urandom));
                default: send_request(($urandom_range(1) ? REQ_LOAD_B : REQ_LOAD_A),
                    3'($urandom), 3'($urandom), 16'($urandom));
            endcase
            n++;
        end
        wait_empty();
        done = 1'b1;
        if (board.failures == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
